FILE: sv/dhb_pkg.sv
// ----------------------------------------------------------------------------
// Dual H-bridge PWM driver package
// Shared widths, register indexes and the control struct that drives the
// serial duty lanes.
// ----------------------------------------------------------------------------
package dhb_pkg;

  // Counter and compare width (fixed by the 16-bit duty fields).
  localparam int CountW = 16;
  localparam logic [CountW-1:0] CountMax = '1;

  // Throttle format: signed Q2.14.
  localparam int ThrW     = 16;
  localparam int MagW     = ThrW + 1;
  localparam int FracBits = 14;
  localparam int FullScale = 1 << FracBits;

  // Configuration register fields.
  localparam int FreqW     = 16;
  localparam int DeadbandW = 15;
  localparam int ResetFreqHz = 1000;
  localparam int DefaultTickRateHz = 2000000;

  // APB register map: register i at byte address 4*i.
  localparam int AddrW = 4;
  localparam int DataW = 32;
  localparam int RegIdxW = 2;
  localparam logic [RegIdxW-1:0] RegFreq     = 2'd0;
  localparam logic [RegIdxW-1:0] RegDeadband = 2'd1;
  localparam logic [RegIdxW-1:0] RegOutputs  = 2'd2;

  // Sequencer commands to a duty lane.
  typedef struct packed {
    logic start;  // capture throttle and classify it
    logic step;   // one shift-add step of the serial multiply
  } lane_ctrl_t;

endpackage

FILE: sv/dhb_in_if.sv
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel that carries one tick or one throttle write.
// ----------------------------------------------------------------------------
interface dhb_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] left_throttle;
  logic signed [15:0] right_throttle;

  modport source (
    output valid, operation, left_throttle, right_throttle,
    input  ready
  );
  modport sink (
    input  valid, operation, left_throttle, right_throttle,
    output ready
  );
endinterface

FILE: sv/dhb_out_if.sv
// ----------------------------------------------------------------------------
// Result item channel
// Valid/ready channel that carries the pin levels, directions and duties.
// ----------------------------------------------------------------------------
interface dhb_out_if;
  logic        valid;
  logic        ready;
  logic        left_pin;
  logic        right_pin;
  logic        left_forward;
  logic        right_forward;
  logic [15:0] left_duty;
  logic [15:0] right_duty;

  modport source (
    output valid, left_pin, right_pin, left_forward, right_forward,
           left_duty, right_duty,
    input  ready
  );
  modport sink (
    input  valid, left_pin, right_pin, left_forward, right_forward,
           left_duty, right_duty,
    output ready
  );
endinterface

FILE: sv/dhb_period_div.sv
// ----------------------------------------------------------------------------
// PWM period divider
// Restoring division of the tick rate by the PWM frequency, one quotient bit
// per cycle, with the quotient saturated to the counter width.
// ----------------------------------------------------------------------------
module dhb_period_div #(
  parameter int TICK_RATE_HZ = dhb_pkg::DefaultTickRateHz
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dhb_pkg::FreqW-1:0]  freq_i,
  output logic                       busy_o,
  output logic [dhb_pkg::CountW-1:0] period_o
);
  import dhb_pkg::*;

  localparam int DvdW = $clog2(TICK_RATE_HZ + 1);
  localparam int CntW = $clog2(DvdW + 1);
  localparam int ResetPeriodInt = TICK_RATE_HZ / ResetFreqHz;
  localparam logic [CountW-1:0] ResetPeriod =
    (ResetPeriodInt > int'(CountMax)) ? CountMax : CountW'(ResetPeriodInt);
  localparam logic [DvdW-1:0] Dividend = DvdW'(TICK_RATE_HZ);
  localparam logic [CntW-1:0] LastStep = CntW'(DvdW - 1);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DvdW-1:0]   dvd_q, dvd_d;
  logic [FreqW-1:0]  dsr_q, dsr_d;
  logic [FreqW-1:0]  rem_q, rem_d;
  logic [CountW-1:0] quo_q, quo_d;
  logic              ovf_q, ovf_d;
  logic [CountW-1:0] period_q, period_d;
  logic [FreqW:0]    trial;
  logic              fits;

  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    dvd_d    = dvd_q;
    dsr_d    = dsr_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    ovf_d    = ovf_q;
    period_d = period_q;
    if (start_i) begin
      if (freq_i == '0) begin
        // A zero frequency gives the longest period the counter can hold.
        period_d = CountMax;
        busy_d   = 1'b0;
      end else begin
        busy_d = 1'b1;
        cnt_d  = '0;
        dvd_d  = Dividend;
        dsr_d  = freq_i;
        rem_d  = '0;
        quo_d  = '0;
        ovf_d  = 1'b0;
      end
    end else if (busy_q) begin
      rem_d = fits ? FreqW'(trial - {1'b0, dsr_q}) : trial[FreqW-1:0];
      quo_d = {quo_q[CountW-2:0], fits};
      ovf_d = ovf_q | quo_q[CountW-1];
      dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d   = 1'b0;
        period_d = ovf_d ? CountMax : quo_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      period_q <= ResetPeriod;
    end else begin
      busy_q   <= busy_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      period_q <= period_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o   = busy_q;
  assign period_o = period_q;

endmodule

FILE: sv/dhb_duty_lane.sv
// ----------------------------------------------------------------------------
// Serial duty lane
// Turns one throttle into a pending compare value: deadband and full-scale
// checks, then a shift-add multiply by the period, one throttle bit a step.
// ----------------------------------------------------------------------------
module dhb_duty_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dhb_pkg::lane_ctrl_t           ctrl_i,
  input  logic signed [dhb_pkg::ThrW-1:0] throttle_i,
  input  logic [dhb_pkg::DeadbandW-1:0] deadband_i,
  input  logic [dhb_pkg::CountW-1:0]    period_i,
  output logic [dhb_pkg::CountW-1:0]    duty_o
);
  import dhb_pkg::*;

  logic [MagW-1:0]     mag;
  logic                below, full;
  logic [CountW-1:0]   acc_q, acc_d;
  logic [FracBits-1:0] mul_q, mul_d;
  logic                run_q, run_d;
  logic [CountW:0]     sum;

  // Magnitude of a two's complement value; the most negative throttle
  // yields 32768.
  assign mag   = throttle_i[ThrW-1] ? (MagW'(1 << ThrW) - {1'b0, throttle_i})
                                    : {1'b0, throttle_i};
  assign below = (mag < MagW'(deadband_i));
  assign full  = (mag >= MagW'(FullScale));

  assign sum = {1'b0, acc_q} + (mul_q[0] ? {1'b0, period_i} : '0);

  always_comb begin
    acc_d = acc_q;
    mul_d = mul_q;
    run_d = run_q;
    if (ctrl_i.start) begin
      mul_d = mag[FracBits-1:0];
      priority if (below) begin
        acc_d = '0;
        run_d = 1'b0;
      end else if (full) begin
        acc_d = period_i;
        run_d = 1'b0;
      end else begin
        acc_d = '0;
        run_d = 1'b1;
      end
    end else if (ctrl_i.step && run_q) begin
      // Product bits below the binary point fall off the low end.
      acc_d = sum[CountW:1];
      mul_d = {1'b0, mul_q[FracBits-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      run_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
  end

  assign duty_o = acc_q;

endmodule

FILE: sv/dual_hbridge_pwm_driver_top.sv
// ----------------------------------------------------------------------------
// Dual H-bridge PWM driver, top level
// Two PWM channels with direction bits, a throttle deadband and compare
// values that take effect at the counter wrap.
// ----------------------------------------------------------------------------
// Each input item is either one tick of the fixed TICK_RATE_HZ clock or a
// throttle write, and each gives exactly one result item. A tick is handled
// in the cycle it is accepted, so its result is offered on the next cycle.
// A throttle write runs both duty lanes in parallel through a 14-step serial
// shift-add multiply, one throttle bit per cycle, and its result is loaded in
// the load state after the last step; no new item is taken meanwhile. Direction
// bits update immediately, and the new compare values become active at the
// next counter wrap. The result register lets the next item be accepted in
// the same cycle that the previous result is taken. Writing the frequency
// register starts a bit-serial division of TICK_RATE_HZ by the frequency,
// one quotient bit per cycle; input items are held off until the new
// period is ready. A frequency of zero selects the longest period at once.
// Registers sit at byte addresses 0 (frequency), 4 (deadband) and 8
// (output enable) and read back as written.
// ----------------------------------------------------------------------------
module dual_hbridge_pwm_driver_top #(
  parameter int TICK_RATE_HZ = dhb_pkg::DefaultTickRateHz
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  dhb_in_if.sink                    item_i,
  dhb_out_if.source                 result_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dhb_pkg::AddrW-1:0] paddr,
  input  logic [dhb_pkg::DataW-1:0] pwdata,
  output logic [dhb_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import dhb_pkg::*;

  // Sequencer state codes.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StLoad = 2'd2;

  localparam int StepW = $clog2(FracBits);
  localparam logic [StepW-1:0] LastStep = StepW'(FracBits - 1);

  // Configuration registers.
  logic [FreqW-1:0]     freq_q;
  logic [DeadbandW-1:0] deadband_q;
  logic                 outputs_on_q;
  logic                 cfg_wr;
  logic [RegIdxW-1:0]   cfg_idx;
  logic                 div_start;
  logic                 div_busy;
  logic [CountW-1:0]    period;

  // PWM state.
  logic [CountW-1:0] tick_q, tick_d;
  logic [CountW-1:0] act_l_q, act_l_d;
  logic [CountW-1:0] act_r_q, act_r_d;
  logic              dir_l_q, dir_l_d;
  logic              dir_r_q, dir_r_d;
  logic [CountW-1:0] pend_l, pend_r;

  // Sequencer.
  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  lane_ctrl_t       lane_ctrl;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic              pin_l_q, pin_r_q;
  logic              fwd_l_q, fwd_r_q;
  logic [CountW-1:0] duty_l_q, duty_r_q;
  logic              pin_l, pin_r;

  logic in_accept;
  logic is_tick, is_write;
  logic wrap;
  logic [CountW-1:0] tick_nx, act_l_nx, act_r_nx;

  // --------------------------------------------------------------------------
  // APB configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[AddrW-1:2];
  assign div_start = cfg_wr && (cfg_idx == RegFreq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q       <= FreqW'(ResetFreqHz);
      deadband_q   <= '0;
      outputs_on_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegFreq:     freq_q       <= pwdata[FreqW-1:0];
        RegDeadband: deadband_q   <= pwdata[DeadbandW-1:0];
        RegOutputs:  outputs_on_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegFreq:     prdata = DataW'(freq_q);
      RegDeadband: prdata = DataW'(deadband_q);
      RegOutputs:  prdata = DataW'(outputs_on_q);
      default:     prdata = '0;
    endcase
  end

  dhb_period_div #(
    .TICK_RATE_HZ(TICK_RATE_HZ)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .freq_i  (pwdata[FreqW-1:0]),
    .busy_o  (div_busy),
    .period_o(period)
  );

  // --------------------------------------------------------------------------
  // Input handshake and sequencer
  // --------------------------------------------------------------------------
  // An item is taken only when the sequencer and divider are free and the
  // result register is empty or being emptied in this cycle.
  assign item_i.ready = (state_q == StIdle) && !div_busy &&
                        (!out_valid_q || result_o.ready);
  assign in_accept = item_i.valid && item_i.ready;
  assign is_tick   = in_accept && !item_i.operation;
  assign is_write  = in_accept && item_i.operation;

  assign lane_ctrl.start = is_write;
  assign lane_ctrl.step  = (state_q == StMul);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (is_write) begin
          state_d = StMul;
          step_d  = '0;
        end
      end
      StMul: begin
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  dhb_duty_lane u_lane_l (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (lane_ctrl),
    .throttle_i(item_i.left_throttle),
    .deadband_i(deadband_q),
    .period_i  (period),
    .duty_o    (pend_l)
  );

  dhb_duty_lane u_lane_r (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (lane_ctrl),
    .throttle_i(item_i.right_throttle),
    .deadband_i(deadband_q),
    .period_i  (period),
    .duty_o    (pend_r)
  );

  // --------------------------------------------------------------------------
  // PWM counter, active compares and direction bits
  // --------------------------------------------------------------------------
  // The counter runs 0..period inclusive; a counter left past a shrunken
  // period wraps on its next tick. Pending compares are copied at the wrap.
  assign wrap     = (tick_q >= period);
  assign tick_nx  = wrap ? '0 : tick_q + 1'b1;
  assign act_l_nx = wrap ? pend_l : act_l_q;
  assign act_r_nx = wrap ? pend_r : act_r_q;

  always_comb begin
    tick_d  = tick_q;
    act_l_d = act_l_q;
    act_r_d = act_r_q;
    dir_l_d = dir_l_q;
    dir_r_d = dir_r_q;
    if (is_tick) begin
      tick_d  = tick_nx;
      act_l_d = act_l_nx;
      act_r_d = act_r_nx;
    end
    if (is_write) begin
      dir_l_d = !item_i.left_throttle[ThrW-1];
      dir_r_d = !item_i.right_throttle[ThrW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      act_l_q <= '0;
      act_r_q <= '0;
      dir_l_q <= 1'b1;
      dir_r_q <= 1'b1;
    end else begin
      tick_q  <= tick_d;
      act_l_q <= act_l_d;
      act_r_q <= act_r_d;
      dir_l_q <= dir_l_d;
      dir_r_q <= dir_r_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  // A tick shows the pins after its own advance; a throttle write shows them
  // against the unchanged counter and active compares.
  assign out_load = is_tick || (state_q == StLoad);
  assign pin_l = outputs_on_q && (is_tick ? (tick_nx < act_l_nx) : (tick_q < act_l_q));
  assign pin_r = outputs_on_q && (is_tick ? (tick_nx < act_r_nx) : (tick_q < act_r_q));

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pin_l_q  <= pin_l;
      pin_r_q  <= pin_r;
      fwd_l_q  <= dir_l_d;
      fwd_r_q  <= dir_r_d;
      duty_l_q <= pend_l;
      duty_r_q <= pend_r;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.left_pin      = pin_l_q;
  assign result_o.right_pin     = pin_r_q;
  assign result_o.left_forward  = fwd_l_q;
  assign result_o.right_forward = fwd_r_q;
  assign result_o.left_duty     = duty_l_q;
  assign result_o.right_duty    = duty_r_q;

`ifndef SYNTHESIS
  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !out_load)
    else $error("result register overwritten while stalled");

  // No item is taken while a throttle write is still being worked on.
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_accept)
    else $error("item accepted during multiply");

  // No item is taken while a new period is being computed.
  a_div_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !in_accept)
    else $error("item accepted during period division");

  // The multiply ends after its last step and loads the result next.
  a_mul_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul && step_q == LastStep) |=> (state_q == StLoad && out_load))
    else $error("multiply did not finish on its last step");
`endif

endmodule
